FILE: rtl/rgabl_pkg.sv
package rgabl_pkg;

  localparam int PIX_X_W = 10;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ROW   = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_kind_t;

  typedef enum logic [1:0] {
    BK_INIT  = 2'd0,
    BK_CLEAR = 2'd1,
    BK_RUN   = 2'd2
  } bk_state_t;

  // members listed from the top bit down, so the first field sits highest
  typedef struct packed {
    logic [7:0]         run_byte;
    logic [7:0]         code_byte;
    logic               restart;
    logic [15:0]        color;
    logic signed [10:0] x_pos;
    cmd_t               command;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        pixel_value;
    logic [PIX_X_W-1:0] pixel_x;
    logic               pixel_written;
    logic [1:0]         bytes_used;
  } out_item_t;

  // work item handed from the decoder to the line-store engine
  typedef struct packed {
    op_kind_t           kind;
    logic [1:0]         bytes_used;
    logic [PIX_X_W-1:0] addr;
    logic [5:0]         cov;
    logic [15:0]        fg;
  } entry_t;

  function automatic logic [7:0] ch_r(input logic [15:0] v);
    ch_r = {v[7:3], 3'b000};
  endfunction

  function automatic logic [7:0] ch_g(input logic [15:0] v);
    ch_g = {v[2:0], v[15:13], 2'b00};
  endfunction

  function automatic logic [7:0] ch_b(input logic [15:0] v);
    ch_b = {v[12:8], 3'b000};
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    pack565 = {g[4:2], b[7:3], r[7:3], g[7:5]};
  endfunction

endpackage

FILE: rtl/rgabl_front.sv
module rgabl_front
  import rgabl_pkg::*;
#(
  parameter int LINE_WIDTH = 240
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  in_item_t item,
  input  logic     init_busy,
  input  logic     q_full,
  output logic     q_push,
  output entry_t   q_entry
);

  localparam logic [PIX_X_W-1:0] LW = PIX_X_W'(LINE_WIDTH);

  logic [5:0]  coverage_r, coverage_nxt;
  logic [7:0]  run_left_r, run_left_nxt;
  logic [10:0] column_r, column_nxt;
  logic [15:0] fg_r, fg_nxt;
  logic        col_in_line;
  logic        xp_in_line;

  assign in_tready   = !init_busy && !q_full;
  assign q_push      = in_tvalid && in_tready;
  assign col_in_line = !column_r[10] && (column_r[PIX_X_W-1:0] < LW);
  assign xp_in_line  = !item.x_pos[10] && (item.x_pos[PIX_X_W-1:0] < LW);

  always_comb begin
    coverage_nxt = coverage_r;
    run_left_nxt = run_left_r;
    column_nxt   = column_r;
    fg_nxt       = fg_r;
    q_entry      = '0;
    q_entry.kind = OP_NONE;
    if (q_push) begin
      unique case (item.command)
        CMD_CLEAR: begin
          q_entry.kind = OP_CLEAR;
        end
        CMD_ROW: begin
          column_nxt = item.x_pos;
          fg_nxt     = item.color;
          if (item.restart) begin
            coverage_nxt = '0;
            run_left_nxt = '0;
          end
        end
        CMD_STEP: begin
          if (run_left_r == 8'd0) begin
            coverage_nxt       = item.code_byte[5:0];
            q_entry.bytes_used = 2'd1;
            if (item.code_byte[7]) begin
              // a zero length wraps to a run of 256
              run_left_nxt       = item.run_byte - 8'd1;
              q_entry.bytes_used = 2'd2;
            end
          end else begin
            run_left_nxt = run_left_r - 8'd1;
          end
          column_nxt = column_r + 11'd1;
          if (col_in_line) begin
            q_entry.kind = OP_WRITE;
            q_entry.addr = column_r[PIX_X_W-1:0];
            q_entry.cov  = coverage_nxt;
            q_entry.fg   = fg_r;
          end
        end
        CMD_READ: begin
          if (xp_in_line) begin
            q_entry.kind = OP_READ;
            q_entry.addr = item.x_pos[PIX_X_W-1:0];
          end
        end
        default: begin
          q_entry.kind = OP_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coverage_r <= '0;
      run_left_r <= '0;
      column_r   <= '0;
      fg_r       <= '0;
    end else begin
      coverage_r <= coverage_nxt;
      run_left_r <= run_left_nxt;
      column_r   <= column_nxt;
      fg_r       <= fg_nxt;
    end
  end

endmodule

FILE: rtl/rgabl_queue.sv
module rgabl_queue
  import rgabl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t         slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == (QAW+1)'(QDEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/rgabl_back.sv
module rgabl_back
  import rgabl_pkg::*;
#(
  parameter int LINE_WIDTH = 240
) (
  input  logic      clk,
  input  logic      rst_n,
  input  entry_t    head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      init_busy,
  output logic      out_tvalid,
  input  logic      out_tready,
  output out_item_t out_item
);

  localparam int AW = $clog2(LINE_WIDTH);

  bk_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [15:0] mem [LINE_WIDTH];
  logic [15:0] rd_data_r;

  logic   s1_valid_r;
  entry_t s1_r;

  logic               s2_valid_r;
  op_kind_t           s2_kind_r;
  logic [1:0]         s2_bytes_r;
  logic [PIX_X_W-1:0] s2_addr_r;
  logic [15:0]        s2_old_r;
  logic [15:0]        pr_old_r, pr_fg_r, pg_old_r, pg_fg_r, pb_old_r, pb_fg_r;

  logic      out_valid_r;
  out_item_t out_r;

  logic        adv;
  logic        head_hits;
  logic        hazard;
  logic        issue_item;
  logic        issue_clr;
  logic [7:0]  cl, ncl;
  logic [15:0] sum_r, sum_g, sum_b;
  logic [15:0] blend_val;
  out_item_t   res;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0] mem_wd;

  assign adv       = !out_valid_r || out_tready;
  assign init_busy = (state_r == BK_INIT);

  // hold a write or read of a column whose new value is still in flight
  assign head_hits = (head.kind == OP_WRITE) || (head.kind == OP_READ);
  assign hazard    = head_hits &&
                     ((s1_valid_r && s1_r.kind == OP_WRITE && s1_r.addr == head.addr) ||
                      (s2_valid_r && s2_kind_r == OP_WRITE && s2_addr_r == head.addr));
  assign issue_item = (state_r == BK_RUN) && !q_empty && adv &&
                      head.kind != OP_CLEAR && !hazard;
  // drain the pipe before a sweep so no stale write lands after it
  assign issue_clr  = (state_r == BK_RUN) && !q_empty && adv &&
                      head.kind == OP_CLEAR && !s1_valid_r && !s2_valid_r;
  assign q_pop      = issue_item || issue_clr;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      BK_INIT, BK_CLEAR: begin
        if (clr_cnt_r == AW'(LINE_WIDTH - 1)) begin
          state_nxt   = BK_RUN;
          clr_cnt_nxt = '0;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      BK_RUN: begin
        if (issue_clr) begin
          state_nxt = BK_CLEAR;
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_INIT;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // stage 2: sum the weighted channels and repack
  always_comb begin
    sum_r     = pr_old_r + pr_fg_r;
    sum_g     = pg_old_r + pg_fg_r;
    sum_b     = pb_old_r + pb_fg_r;
    blend_val = pack565(sum_r[15:8], sum_g[15:8], sum_b[15:8]);
    res       = '0;
    res.bytes_used = s2_bytes_r;
    unique case (s2_kind_r)
      OP_WRITE: begin
        res.pixel_written = 1'b1;
        res.pixel_x       = s2_addr_r;
        res.pixel_value   = blend_val;
      end
      OP_READ: begin
        res.pixel_x     = s2_addr_r;
        res.pixel_value = s2_old_r;
      end
      OP_NONE, OP_CLEAR: begin
        res.pixel_x = '0;
      end
      default: begin
        res.pixel_x = '0;
      end
    endcase
  end

  always_comb begin
    if (state_r != BK_RUN) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = adv && s2_valid_r && (s2_kind_r == OP_WRITE);
      mem_wa = s2_addr_r[AW-1:0];
      mem_wd = blend_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (adv) begin
      rd_data_r <= mem[head.addr[AW-1:0]];
    end
  end

  assign cl  = {s1_r.cov, 2'b00};
  assign ncl = {~s1_r.cov, 2'b00};

  // advance the whole pipe together with the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= head;
      s2_kind_r  <= s1_r.kind;
      s2_bytes_r <= s1_r.bytes_used;
      s2_addr_r  <= s1_r.addr;
      s2_old_r   <= rd_data_r;
      pr_old_r   <= ncl * ch_r(rd_data_r);
      pr_fg_r    <= cl  * ch_r(s1_r.fg);
      pg_old_r   <= ncl * ch_g(rd_data_r);
      pg_fg_r    <= cl  * ch_g(s1_r.fg);
      pb_old_r   <= ncl * ch_b(rd_data_r);
      pb_fg_r    <= cl  * ch_b(s1_r.fg);
      out_r      <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_pop;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_item   = out_r;

endmodule

FILE: rtl/rle_glyph_alpha_blend_line_top.sv
// Path: an item passes the queue, stage 1, stage 2 and the output register.
// Throughput: one item per cycle when nothing stalls; a pixel step or read that hits a
//   column still being written waits for the read-modify-write loop on the line memory.
// Clear line: waits for the pipe to drain, then the memory is swept while later items
//   wait; its own result goes on down the pipe during the sweep.
// Reset: rst_n is synchronous, active low; afterwards in_tready stays low while the
//   line memory is swept to zero.
module rle_glyph_alpha_blend_line_top
  import rgabl_pkg::*;
#(
  parameter int LINE_WIDTH = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[1:0], x_pos[12:2], color[28:13], restart[29], code_byte[37:30],
  // run_byte[45:38], zero fill[47:46]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bytes_used[1:0], pixel_written[2], pixel_x[12:3], pixel_value[28:13],
  // zero fill[31:29]
  output logic [31:0] out_tdata
);

  in_item_t  item;
  out_item_t out_item;
  entry_t    q_entry;
  entry_t    q_head;
  logic      q_push;
  logic      q_pop;
  logic      q_empty;
  logic      q_full;
  logic      init_busy;

  assign item      = in_item_t'(in_tdata[45:0]);
  assign out_tdata = {3'b000, out_item};

  rgabl_front #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .item      (item),
    .init_busy (init_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  rgabl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  rgabl_back #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item)
  );

endmodule

FILE: tb/blend_line_checker.sv
`timescale 1ns / 1ps

module blend_line_checker
  import rgabl_pkg::*;
#(
  parameter int LINE_WIDTH = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          errors,
  output int          pending,
  output int          steps_seen,
  output int          pixels_blended,
  output int          reads_seen
);

  logic [15:0]        line_mem [LINE_WIDTH];
  logic [5:0]         cov_q;
  logic [7:0]         run_q;
  logic signed [10:0] col_q;
  logic [15:0]        fg_q;
  out_item_t          pixel_results_due [$];

  initial begin
    errors         = 0;
    pending        = 0;
    steps_seen     = 0;
    pixels_blended = 0;
    reads_seen     = 0;
  end

  // pull the old pixel toward the foreground by the 6-bit coverage
  function automatic logic [15:0] blend_toward(input logic [15:0] old_px,
                                               input logic [15:0] fg_px,
                                               input logic [5:0]  cov);
    int unsigned o, f, cl, ncl, ro, go, bo, rf, gf, bf, r, g, b, v;
    o   = 32'(old_px);
    f   = 32'(fg_px);
    cl  = int'(cov) * 4;
    ncl = (63 - int'(cov)) * 4;
    ro  = o & 'hF8;
    bo  = (o >> 5) & 'hF8;
    go  = ((o & 7) << 5) | ((o & 'hE000) >> 11);
    rf  = f & 'hF8;
    bf  = (f >> 5) & 'hF8;
    gf  = ((f & 7) << 5) | ((f & 'hE000) >> 11);
    r   = (ncl * ro + cl * rf) >> 8;
    g   = (ncl * go + cl * gf) >> 8;
    b   = (ncl * bo + cl * bf) >> 8;
    v   = ((b & 'hF8) << 5) + (r & 'hF8) + ((g & 'hE0) >> 5) + ((g & 'h1C) << 11);
    return v[15:0];
  endfunction

  function automatic out_item_t next_pixel_result(input in_item_t it);
    out_item_t res;
    int        idx;
    res = '0;
    case (it.command)
      CMD_CLEAR: begin
        for (int i = 0; i < LINE_WIDTH; i++) line_mem[i] = '0;
      end
      CMD_ROW: begin
        col_q = it.x_pos;
        fg_q  = it.color;
        if (it.restart) begin
          cov_q = '0;
          run_q = '0;
        end
      end
      CMD_STEP: begin
        steps_seen++;
        if (run_q == 8'd0) begin
          cov_q          = it.code_byte[5:0];
          res.bytes_used = 2'd1;
          if (it.code_byte[7]) begin
            // a zero length wraps to a run of 256
            run_q          = it.run_byte - 8'd1;
            res.bytes_used = 2'd2;
          end
        end else begin
          run_q = run_q - 8'd1;
        end
        if (col_q >= 0 && col_q < LINE_WIDTH) begin
          idx               = int'(col_q);
          line_mem[idx]     = blend_toward(line_mem[idx], fg_q, cov_q);
          res.pixel_written = 1'b1;
          res.pixel_x       = col_q[9:0];
          res.pixel_value   = line_mem[idx];
          pixels_blended++;
        end
        col_q = col_q + 11'sd1;
      end
      CMD_READ: begin
        reads_seen++;
        if (it.x_pos >= 0 && it.x_pos < LINE_WIDTH) begin
          idx             = int'(it.x_pos);
          res.pixel_x     = it.x_pos[9:0];
          res.pixel_value = line_mem[idx];
        end
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINE_WIDTH; i++) line_mem[i] = '0;
      cov_q = '0;
      run_q = '0;
      col_q = '0;
      fg_q  = '0;
      pixel_results_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_item_t'(out_tdata[28:0]);
        if (pixel_results_due.size() == 0) begin
          $error("result transfer with nothing expected: 0x%0h", out_tdata);
          errors++;
        end else begin
          want = pixel_results_due.pop_front();
          check_field("bytes_used", int'(want.bytes_used), int'(got.bytes_used));
          check_field("pixel_written", int'(want.pixel_written), int'(got.pixel_written));
          check_field("pixel_x", int'(want.pixel_x), int'(got.pixel_x));
          check_field("pixel_value", int'(want.pixel_value), int'(got.pixel_value));
        end
      end
      if (in_tvalid && in_tready)
        pixel_results_due.push_back(next_pixel_result(in_item_t'(in_tdata[45:0])));
    end
    pending = pixel_results_due.size();
  end

endmodule

FILE: tb/tb_rle_glyph_alpha_blend_line_top.sv
`timescale 1ns / 1ps

module tb_rle_glyph_alpha_blend_line_top;
  import rgabl_pkg::*;

  localparam int LINE_W      = 240;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 385;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  int errors, pending, steps_seen, pixels_blended, reads_seen;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int items_sent      = 0;
  int run_pending     = 0;
  int cycle_cnt       = 0;

  rle_glyph_alpha_blend_line_top #(
    .LINE_WIDTH(LINE_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  blend_line_checker #(
    .LINE_WIDTH(LINE_W)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .errors        (errors),
    .pending       (pending),
    .steps_seen    (steps_seen),
    .pixels_blended(pixels_blended),
    .reads_seen    (reads_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_item_t mk(input cmd_t cmd, input int x, input logic [15:0] color,
                                  input logic restart, input logic [7:0] code,
                                  input logic [7:0] runb);
    in_item_t it;
    it.command   = cmd;
    it.x_pos     = x[10:0];
    it.color     = color;
    it.restart   = restart;
    it.code_byte = code;
    it.run_byte  = runb;
    return it;
  endfunction

  // hold the item until the transfer, idling beforehand at the phase's rate
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, it};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // offer coded bytes the way an encoder would lay them out
  task automatic send_step();
    logic [7:0] code;
    logic [7:0] runb;
    code = 8'($urandom);
    runb = 8'($urandom);
    if (run_pending > 0) begin
      run_pending--;
    end else if ($urandom_range(9) < 6) begin
      code[7] = 1'b0;
    end else begin
      code[7] = 1'b1;
      runb = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 8));
      run_pending = (runb == 8'd0) ? 255 : int'(runb) - 1;
    end
    send(mk(CMD_STEP, $urandom, 16'($urandom), 1'($urandom), code, runb));
  endtask

  task automatic send_row();
    int         x;
    int         n_steps;
    int         roll;
    logic       restart;
    if ($urandom_range(99) < 3)
      send(mk(CMD_CLEAR, $urandom, 16'($urandom), 1'($urandom), 8'($urandom),
              8'($urandom)));
    if ($urandom_range(9) == 0)
      x = int'($urandom_range(2047)) - 1024;
    else
      x = int'($urandom_range(LINE_W + 7)) - 8;
    restart = ($urandom_range(3) != 0);
    send(mk(CMD_ROW, x, 16'($urandom), restart, 8'($urandom), 8'($urandom)));
    if (restart) run_pending = 0;
    n_steps = $urandom_range(1, 40);
    repeat (n_steps) begin
      roll = $urandom_range(99);
      if (roll < 4)
        send(in_item_t'(46'({$urandom, $urandom})));
      else if (roll < 12)
        send(mk(CMD_READ, int'($urandom_range(LINE_W + 3)) - 2, 16'($urandom),
                1'($urandom), 8'($urandom), 8'($urandom)));
      else
        send_step();
    end
  endtask

  initial begin
    int target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reads at and past both ends of the line
    send(mk(CMD_READ, 0, 16'h0, 1'b0, 8'h00, 8'h00));
    send(mk(CMD_READ, LINE_W - 1, 16'hFFFF, 1'b1, 8'hFF, 8'hFF));
    send(mk(CMD_READ, LINE_W, 16'h0, 1'b0, 8'h00, 8'h00));
    send(mk(CMD_READ, -1, 16'h0, 1'b0, 8'h00, 8'h00));
    // literals: full coverage, masked literal, zero coverage
    send(mk(CMD_ROW, 0, 16'hFFFF, 1'b1, 8'h00, 8'h00));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'h3F, 8'hFF));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'h7F, 8'h00));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'h00, 8'h00));
    // short run, then a zero-length header for the longest run
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'hA0, 8'h03));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'h12, 8'h34));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'hFF, 8'hFF));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'hBF, 8'h00));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'h01, 8'h02));
    // carry the run into a row that runs off the right edge
    send(mk(CMD_ROW, LINE_W - 2, 16'h1234, 1'b0, 8'h00, 8'h00));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'h05, 8'h00));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'h05, 8'h00));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'h05, 8'h00));
    // wrap the column from the top of the signed range
    send(mk(CMD_ROW, 1023, 16'hF81F, 1'b1, 8'h00, 8'h00));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'h55, 8'h00));
    send(mk(CMD_STEP, 0, 16'h0, 1'b0, 8'h80, 8'h01));
    send(mk(CMD_READ, 0, 16'h0, 1'b0, 8'h00, 8'h00));
    send(mk(CMD_CLEAR, 0, 16'h0, 1'b0, 8'h00, 8'h00));
    send(mk(CMD_READ, 0, 16'h0, 1'b0, 8'h00, 8'h00));
    send(mk(CMD_READ, 1023, 16'h0, 1'b0, 8'h00, 8'h00));
    run_pending = 0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin sender_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_row();
    end

    in_tvalid <= 1'b0;
    // let the checker log the last transfer before looking at its backlog
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d transfers in: %0d pixel steps (%0d blended into the line), %0d reads",
             items_sent, steps_seen, pixels_blended, reads_seen);
    $display("idle phases: none, sender 82%%, receiver 82%%, both 23%%");
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
